// ===== src/teoq_pkg.sv =====
package teoq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_TIME_BITS   = 20;
   localparam int DEF_OWNER_BITS  = 8;

   localparam int OP_BITS     = 2;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_LOOKUP = 2'd3
   } teoq_op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } teoq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY
   } teoq_state_type;

   typedef struct packed {
      logic req_load;
      logic match_load;
      logic apply;
   } teoq_cmd_type;

endpackage

// ===== src/teoq_req_if.sv =====
interface teoq_req_if #(
   parameter int TIME_BITS  = teoq_pkg::DEF_TIME_BITS,
   parameter int OWNER_BITS = teoq_pkg::DEF_OWNER_BITS
);
   logic                              valid;
   logic                              ready;
   logic [teoq_pkg::OP_BITS-1:0]      command;
   logic [OWNER_BITS-1:0]             owner_id;
   logic [TIME_BITS-1:0]              event_time;
   logic [teoq_pkg::KIND_BITS-1:0]    transition_kind;

   modport source (
      output valid, command, owner_id, event_time, transition_kind,
      input  ready
   );

   modport sink (
      input  valid, command, owner_id, event_time, transition_kind,
      output ready
   );
endinterface

// ===== src/teoq_rsp_if.sv =====
interface teoq_rsp_if #(
   parameter int TIME_BITS  = teoq_pkg::DEF_TIME_BITS,
   parameter int OWNER_BITS = teoq_pkg::DEF_OWNER_BITS
);
   logic                              valid;
   logic                              ready;
   logic [OWNER_BITS-1:0]             out_owner_id;
   logic [TIME_BITS-1:0]              out_time;
   logic [teoq_pkg::KIND_BITS-1:0]    out_transition;
   logic [teoq_pkg::STATUS_BITS-1:0]  status;
   logic                              queue_empty;
   logic [TIME_BITS-1:0]              head_time;

   modport source (
      output valid, out_owner_id, out_time, out_transition, status, queue_empty,
             head_time,
      input  ready
   );

   modport sink (
      input  valid, out_owner_id, out_time, out_transition, status, queue_empty,
             head_time,
      output ready
   );
endinterface

// ===== src/timestamp_ordered_event_queue.sv =====
// Each request passes the capture, compare and apply steps of the controller, and its
// result is registered at apply, which waits while an earlier result is still held. A new
// request is taken only in idle, but a pending result does not block its transfer.
// Reset: synchronous, active high; it empties the queue at once and drops any
// pending result. Stored event payloads are not cleared.
module timestamp_ordered_event_queue #(
   parameter int QUEUE_DEPTH = teoq_pkg::DEF_QUEUE_DEPTH,
   parameter int TIME_BITS   = teoq_pkg::DEF_TIME_BITS,
   parameter int OWNER_BITS  = teoq_pkg::DEF_OWNER_BITS
) (
   input  logic        clock,
   input  logic        reset,
   teoq_req_if.sink    req_chan,
   teoq_rsp_if.source  rsp_chan
);
   import teoq_pkg::*;

   teoq_cmd_type cmd;

   teoq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   teoq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .OWNER_BITS  (OWNER_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_command         (req_chan.command),
      .req_owner_id        (req_chan.owner_id),
      .req_event_time      (req_chan.event_time),
      .req_transition_kind (req_chan.transition_kind),
      .rsp_out_owner_id    (rsp_chan.out_owner_id),
      .rsp_out_time        (rsp_chan.out_time),
      .rsp_out_transition  (rsp_chan.out_transition),
      .rsp_status          (rsp_chan.status),
      .rsp_queue_empty     (rsp_chan.queue_empty),
      .rsp_head_time       (rsp_chan.head_time)
   );

endmodule

// ===== src/teoq_ctrl.sv =====
module teoq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output teoq_pkg::teoq_cmd_type cmd
);
   import teoq_pkg::*;

   teoq_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match_load = 1'b1;
            state_in       = ST_APPLY;
         end
         ST_APPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/teoq_datapath.sv =====
module teoq_datapath #(
   parameter int QUEUE_DEPTH = teoq_pkg::DEF_QUEUE_DEPTH,
   parameter int TIME_BITS   = teoq_pkg::DEF_TIME_BITS,
   parameter int OWNER_BITS  = teoq_pkg::DEF_OWNER_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  teoq_pkg::teoq_cmd_type               cmd,
   input  logic [teoq_pkg::OP_BITS-1:0]         req_command,
   input  logic [OWNER_BITS-1:0]                req_owner_id,
   input  logic [TIME_BITS-1:0]                 req_event_time,
   input  logic [teoq_pkg::KIND_BITS-1:0]       req_transition_kind,
   output logic [OWNER_BITS-1:0]                rsp_out_owner_id,
   output logic [TIME_BITS-1:0]                 rsp_out_time,
   output logic [teoq_pkg::KIND_BITS-1:0]       rsp_out_transition,
   output logic [teoq_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic                                 rsp_queue_empty,
   output logic [TIME_BITS-1:0]                 rsp_head_time
);
   import teoq_pkg::*;

   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam logic [QUEUE_DEPTH-1:0] ONE_VEC = {{(QUEUE_DEPTH-1){1'b0}}, 1'b1};

   teoq_op_type             op_ff;
   logic [OWNER_BITS-1:0]   owner_ff;
   logic [TIME_BITS-1:0]    time_ff;
   logic [KIND_BITS-1:0]    kind_ff;

   logic [QUEUE_DEPTH-1:0]  slot_valid_ff, slot_valid_in;
   logic [TIME_BITS-1:0]    slot_time_ff  [QUEUE_DEPTH];
   logic [TIME_BITS-1:0]    slot_time_in  [QUEUE_DEPTH];
   logic [OWNER_BITS-1:0]   slot_owner_ff [QUEUE_DEPTH];
   logic [OWNER_BITS-1:0]   slot_owner_in [QUEUE_DEPTH];
   logic [KIND_BITS-1:0]    slot_kind_ff  [QUEUE_DEPTH];
   logic [KIND_BITS-1:0]    slot_kind_in  [QUEUE_DEPTH];

   logic [QUEUE_DEPTH-1:0]  match_ff, match_in;
   logic [QUEUE_DEPTH-1:0]  greater_ff, greater_in;

   logic [OWNER_BITS-1:0]   rsp_owner_ff, rsp_owner_in;
   logic [TIME_BITS-1:0]    rsp_time_ff, rsp_time_in;
   logic [KIND_BITS-1:0]    rsp_kind_ff, rsp_kind_in;
   teoq_status_type         rsp_status_ff, rsp_status_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [TIME_BITS-1:0]    rsp_head_ff, rsp_head_in;

   logic                    full;
   logic                    found;
   logic [QUEUE_DEPTH-1:0]  sel_vec;
   logic [QUEUE_DEPTH-1:0]  first_hot;
   logic [QUEUE_DEPTH-1:0]  below;
   logic [QUEUE_DEPTH-1:0]  greater_prev;
   logic [QUEUE_DEPTH-1:0]  valid_prev;
   logic [QUEUE_DEPTH-1:0]  valid_next;
   logic [TIME_BITS-1:0]    look_time;

   // Request capture and per-slot compare results.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff    <= teoq_op_type'(req_command);
         owner_ff <= req_owner_id;
         time_ff  <= req_event_time;
         kind_ff  <= req_transition_kind;
      end
      if (cmd.match_load) begin
         match_ff   <= match_in;
         greater_ff <= greater_in;
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         match_in[i]   = slot_valid_ff[i] && (slot_owner_ff[i] == owner_ff);
         greater_in[i] = slot_valid_ff[i] && (slot_time_ff[i] > time_ff);
      end
   end

   // Position decode shared by pop, remove and lookup.
   always_comb begin
      full         = slot_valid_ff[QUEUE_DEPTH-1];
      sel_vec      = (op_ff == OP_POP) ? (slot_valid_ff & ONE_VEC) : match_ff;
      found        = |sel_vec;
      first_hot    = sel_vec & (~sel_vec + ONE_VEC);
      below        = first_hot - ONE_VEC;
      greater_prev = {greater_ff[QUEUE_DEPTH-2:0], 1'b0};
      valid_prev   = {slot_valid_ff[QUEUE_DEPTH-2:0], 1'b1};
      valid_next   = {1'b0, slot_valid_ff[QUEUE_DEPTH-1:1]};
      look_time    = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (first_hot[i]) begin
            look_time = look_time | slot_time_ff[i];
         end
      end
   end

   // Each slot either holds, takes its lower neighbor, takes its upper
   // neighbor, or takes the new event.
   always_comb begin
      logic [IDX_BITS-1:0] up_idx;
      logic [IDX_BITS-1:0] dn_idx;
      slot_valid_in = slot_valid_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         up_idx           = IDX_BITS'((i == QUEUE_DEPTH - 1) ? i : i + 1);
         dn_idx           = IDX_BITS'((i == 0) ? i : i - 1);
         slot_time_in[i]  = slot_time_ff[i];
         slot_owner_in[i] = slot_owner_ff[i];
         slot_kind_in[i]  = slot_kind_ff[i];
         if (cmd.apply) begin
            case (op_ff)
               OP_INSERT: begin
                  if (!full) begin
                     if (greater_prev[i]) begin
                        slot_time_in[i]  = slot_time_ff[dn_idx];
                        slot_owner_in[i] = slot_owner_ff[dn_idx];
                        slot_kind_in[i]  = slot_kind_ff[dn_idx];
                     end else if (greater_ff[i] || (!slot_valid_ff[i] && valid_prev[i])) begin
                        slot_time_in[i]  = time_ff;
                        slot_owner_in[i] = owner_ff;
                        slot_kind_in[i]  = kind_ff;
                     end
                  end
               end
               OP_POP, OP_REMOVE: begin
                  if (found && !below[i]) begin
                     slot_time_in[i]  = slot_time_ff[up_idx];
                     slot_owner_in[i] = slot_owner_ff[up_idx];
                     slot_kind_in[i]  = slot_kind_ff[up_idx];
                  end
               end
               default: begin
               end
            endcase
         end
      end
      if (cmd.apply) begin
         case (op_ff)
            OP_INSERT: begin
               if (!full) begin
                  slot_valid_in = slot_valid_ff | (~slot_valid_ff & valid_prev);
               end
            end
            OP_POP, OP_REMOVE: begin
               if (found) begin
                  slot_valid_in = (slot_valid_ff & below) | (valid_next & ~below);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_owner_in  = owner_ff;
      rsp_time_in   = '0;
      rsp_kind_in   = '0;
      rsp_status_in = STAT_OK;
      case (op_ff)
         OP_INSERT: begin
            if (full) begin
               rsp_status_in = STAT_FULL;
            end
         end
         OP_POP: begin
            if (slot_valid_ff[0]) begin
               rsp_owner_in = slot_owner_ff[0];
               rsp_time_in  = slot_time_ff[0];
               rsp_kind_in  = slot_kind_ff[0];
            end else begin
               rsp_status_in = STAT_EMPTY;
            end
         end
         OP_REMOVE: begin
            if (!found) begin
               rsp_status_in = STAT_NOT_FOUND;
            end
         end
         OP_LOOKUP: begin
            if (found) begin
               rsp_time_in = look_time;
            end else begin
               rsp_status_in = STAT_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      rsp_empty_in = !slot_valid_in[0];
      rsp_head_in  = slot_valid_in[0] ? slot_time_in[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_time_ff  <= slot_time_in;
      slot_owner_ff <= slot_owner_in;
      slot_kind_ff  <= slot_kind_in;
      if (cmd.apply) begin
         rsp_owner_ff  <= rsp_owner_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_head_ff   <= rsp_head_in;
      end
   end

   assign rsp_out_owner_id   = rsp_owner_ff;
   assign rsp_out_time       = rsp_time_ff;
   assign rsp_out_transition = rsp_kind_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_queue_empty    = rsp_empty_ff;
   assign rsp_head_time      = rsp_head_ff;

endmodule

// ===== src/teoq_checker.sv =====
module teoq_checker #(
   parameter int TIME_BITS  = teoq_pkg::DEF_TIME_BITS,
   parameter int OWNER_BITS = teoq_pkg::DEF_OWNER_BITS
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [OWNER_BITS-1:0]               rsp_out_owner_id,
   input logic [TIME_BITS-1:0]                rsp_out_time,
   input logic [teoq_pkg::STATUS_BITS-1:0]    rsp_status,
   input logic                                rsp_queue_empty,
   input logic [TIME_BITS-1:0]                rsp_head_time
);
   import teoq_pkg::*;

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_owner_id)
         && $stable(rsp_out_time) && $stable(rsp_status))
      else $error("stalled result changed");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // An empty queue reports a zero head time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> rsp_head_time == '0)
      else $error("empty queue with nonzero head time");

   // A pop on an empty queue leaves it empty and returns no time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |-> rsp_queue_empty && rsp_out_time == '0)
      else $error("failed pop with inconsistent result");

   // A full queue is never empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> !rsp_queue_empty)
      else $error("full status on an empty queue");

endmodule

bind timestamp_ordered_event_queue teoq_checker #(
   .TIME_BITS  (TIME_BITS),
   .OWNER_BITS (OWNER_BITS)
) u_teoq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_owner_id (rsp_chan.out_owner_id),
   .rsp_out_time     (rsp_chan.out_time),
   .rsp_status       (rsp_chan.status),
   .rsp_queue_empty  (rsp_chan.queue_empty),
   .rsp_head_time    (rsp_chan.head_time)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import teoq_pkg::*;

   localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
   localparam int TIME_BITS   = DEF_TIME_BITS;
   localparam int OWNER_BITS  = DEF_OWNER_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      teoq_op_type           op;
      logic [OWNER_BITS-1:0] owner;
      logic [TIME_BITS-1:0]  stamp;
      logic [KIND_BITS-1:0]  kind;
   } event_req_type;

   typedef struct packed {
      logic [OWNER_BITS-1:0] owner;
      logic [TIME_BITS-1:0]  stamp;
      logic [KIND_BITS-1:0]  kind;
      teoq_status_type       status;
      logic                  empty;
      logic [TIME_BITS-1:0]  head;
   } event_rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]  stamp;
      logic [OWNER_BITS-1:0] owner;
      logic [KIND_BITS-1:0]  kind;
   } queue_entry_type;

   logic clock;
   logic reset;

   teoq_req_if #(.TIME_BITS(TIME_BITS), .OWNER_BITS(OWNER_BITS)) req_bus ();
   teoq_rsp_if #(.TIME_BITS(TIME_BITS), .OWNER_BITS(OWNER_BITS)) rsp_bus ();

   timestamp_ordered_event_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TIME_BITS(TIME_BITS),
      .OWNER_BITS(OWNER_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   queue_entry_type shadow_slots[QUEUE_DEPTH];
   int              shadow_count = 0;
   event_rsp_type   predicted_replies[$];
   int              fail_count = 0;
   bit              sender_idles = 0;
   bit              receiver_stalls = 0;
   int              hold_off_cycles = 0;
   int              stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic report_failure(input string msg);
      if (fail_count < MAX_PRINTED) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   function automatic void drop_entry(input int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_slots[i] = shadow_slots[i+1];
      end
      shadow_count--;
   endfunction

   // Applies one operation to the shadow queue and returns the reply it causes.
   function automatic event_rsp_type apply_event_op(input event_req_type item);
      event_rsp_type reply;
      int            pos;
      reply.owner  = item.owner;
      reply.stamp  = '0;
      reply.kind   = '0;
      reply.status = STAT_OK;
      case (item.op)
         OP_INSERT: begin
            if (shadow_count == QUEUE_DEPTH) begin
               reply.status = STAT_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_slots[pos].stamp <= item.stamp) pos++;
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_slots[i] = shadow_slots[i-1];
               end
               shadow_slots[pos] = '{stamp: item.stamp, owner: item.owner, kind: item.kind};
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               reply.status = STAT_EMPTY;
            end else begin
               reply.owner = shadow_slots[0].owner;
               reply.stamp = shadow_slots[0].stamp;
               reply.kind  = shadow_slots[0].kind;
               drop_entry(0);
            end
         end
         default: begin
            pos = 0;
            while (pos < shadow_count && shadow_slots[pos].owner != item.owner) pos++;
            if (pos == shadow_count) begin
               reply.status = STAT_NOT_FOUND;
            end else if (item.op == OP_REMOVE) begin
               drop_entry(pos);
            end else begin
               reply.stamp = shadow_slots[pos].stamp;
            end
         end
      endcase
      reply.empty = (shadow_count == 0);
      reply.head  = (shadow_count == 0) ? '0 : shadow_slots[0].stamp;
      return reply;
   endfunction

   task automatic check_reply();
      event_rsp_type want;
      if (predicted_replies.size() == 0) begin
         report_failure("reply with no request outstanding");
         return;
      end
      want = predicted_replies.pop_front();
      if (rsp_bus.out_owner_id !== want.owner)
         report_failure($sformatf("out_owner_id %0h, expected %0h", rsp_bus.out_owner_id,
                                  want.owner));
      if (rsp_bus.out_time !== want.stamp)
         report_failure($sformatf("out_time %0h, expected %0h", rsp_bus.out_time, want.stamp));
      if (rsp_bus.out_transition !== want.kind)
         report_failure($sformatf("out_transition %0d, expected %0d", rsp_bus.out_transition,
                                  want.kind));
      if (rsp_bus.status !== want.status)
         report_failure($sformatf("status %0d, expected %s", rsp_bus.status,
                                  want.status.name()));
      if (rsp_bus.queue_empty !== want.empty)
         report_failure($sformatf("queue_empty %0b, expected %0b", rsp_bus.queue_empty,
                                  want.empty));
      if (rsp_bus.head_time !== want.head)
         report_failure($sformatf("head_time %0h, expected %0h", rsp_bus.head_time, want.head));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predicted_replies.push_back(apply_event_op('{op: teoq_op_type'(req_bus.command),
                                                         owner: req_bus.owner_id,
                                                         stamp: req_bus.event_time,
                                                         kind: req_bus.transition_kind}));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_reply();
         end
      end
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_bus.ready = 1'b0;
         hold_off_cycles--;
      end else if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready = 1'b1;
         if (receiver_stalls && $urandom_range(0, 3) == 0) stall_left = idle_length();
      end
   end

   task automatic send_event(input event_req_type item);
      int gap;
      gap = (sender_idles && $urandom_range(0, 1) == 0) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid           = 1'b1;
      req_bus.command         = item.op;
      req_bus.owner_id        = item.owner;
      req_bus.event_time      = item.stamp;
      req_bus.transition_kind = item.kind;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic event_req_type random_event(input int insert_pct, input int pop_pct);
      event_req_type item;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) item.op = OP_INSERT;
      else if (pick < insert_pct + pop_pct) item.op = OP_POP;
      else if ($urandom_range(0, 1) == 0) item.op = OP_REMOVE;
      else item.op = OP_LOOKUP;
      // A small owner pool makes removes and lookups hit, including duplicates.
      item.owner = ($urandom_range(0, 3) == 0) ? OWNER_BITS'($urandom_range(0, 255))
                                               : OWNER_BITS'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
         0: item.stamp = TIME_BITS'($urandom_range(0, int'(TIME_MAX)));
         1: item.stamp = ($urandom_range(0, 1) == 0) ? '0
                                                     : TIME_MAX - TIME_BITS'($urandom_range(0, 1));
         default: item.stamp = TIME_BITS'($urandom_range(0, 63));
      endcase
      item.kind = KIND_BITS'($urandom_range(0, 3));
      return item;
   endfunction

   task automatic run_random(input int count, input int insert_pct, input int pop_pct);
      repeat (count) send_event(random_event(insert_pct, pop_pct));
   endtask

   task automatic test_directed_cases();
      send_event('{OP_POP,    8'hFF, 20'h5A5A5, 2'd3});
      send_event('{OP_REMOVE, 8'h00, 20'h00000, 2'd0});
      send_event('{OP_LOOKUP, 8'hFF, TIME_MAX,  2'd3});
      send_event('{OP_INSERT, 8'h00, TIME_MAX,  2'd3});
      send_event('{OP_INSERT, 8'hFF, 20'h00000, 2'd0});
      send_event('{OP_INSERT, 8'h01, 20'd500,   2'd1});
      send_event('{OP_INSERT, 8'h02, 20'd500,   2'd2});
      send_event('{OP_INSERT, 8'h01, 20'd500,   2'd3});
      send_event('{OP_INSERT, 8'h07, 20'd499,   2'd1});
      send_event('{OP_LOOKUP, 8'h01, 20'hAAAAA, 2'd2});
      send_event('{OP_LOOKUP, 8'h09, 20'h00000, 2'd0});
      send_event('{OP_REMOVE, 8'h01, 20'h55555, 2'd1});
      send_event('{OP_LOOKUP, 8'h01, 20'h00000, 2'd0});
      send_event('{OP_REMOVE, 8'hFF, 20'h00000, 2'd0});
      send_event('{OP_POP,    8'h80, TIME_MAX,  2'd2});
      send_event('{OP_POP,    8'h00, 20'h00000, 2'd0});
      send_event('{OP_POP,    8'h00, 20'h00000, 2'd0});
      send_event('{OP_POP,    8'h00, 20'h00000, 2'd0});
      send_event('{OP_POP,    8'h3C, 20'h0F0F0, 2'd1});
      send_event('{OP_REMOVE, 8'h01, 20'h00000, 2'd0});
   endtask

   task automatic test_random_back_to_back();
      sender_idles    = 0;
      receiver_stalls = 0;
      run_random(150, 40, 25);
   endtask

   task automatic test_fill_with_idling();
      sender_idles    = 1;
      receiver_stalls = 1;
      run_random(150, 70, 10);
   endtask

   // The receiver holds off while requests, mostly inserts, keep coming, so the input must stall.
   task automatic test_output_backpressure();
      sender_idles    = 0;
      receiver_stalls = 0;
      hold_off_cycles = 150;
      run_random(60, 60, 20);
   endtask

   task automatic test_drain_with_idling();
      sender_idles    = 1;
      receiver_stalls = 1;
      run_random(150, 20, 50);
   endtask

   task automatic test_receiver_stalls_only();
      sender_idles    = 0;
      receiver_stalls = 1;
      run_random(140, 40, 20);
   endtask

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.command         = OP_INSERT;
      req_bus.owner_id        = '0;
      req_bus.event_time      = '0;
      req_bus.transition_kind = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_back_to_back();
      test_fill_with_idling();
      test_output_backpressure();
      test_drain_with_idling();
      test_receiver_stalls_only();

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
